// File: hdl/mmcs_pkg.sv
// Shared types and constants for the min-max contrast stretch block.
package mmcs_pkg;

	localparam int PIXEL_BITS = 16;
	localparam int INPUT_BITS = 16;
	localparam int LEVEL_BITS = 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_IDX_BITS = $clog2(QUEUE_DEPTH);
	localparam int STEP_BITS = $clog2(LEVEL_BITS);

	typedef logic [PIXEL_BITS-1:0] pix_t;
	typedef logic [LEVEL_BITS-1:0] level_t;

	localparam pix_t FULL_SCALE = {PIXEL_BITS{1'b1}};
	localparam level_t LEVEL_MAX = {LEVEL_BITS{1'b1}};
	localparam level_t LEVEL_ZERO = '0;

	// Command codes on the input channel
	localparam logic CMD_MEASURE = 1'b0;
	localparam logic CMD_APPLY = 1'b1;

	// How the back end resolves an apply pixel
	typedef enum logic [1:0] {
		KIND_ZERO,
		KIND_FULL,
		KIND_DIV
	} kind_t;

	// Work handed from front to back
	typedef struct packed {
		kind_t kind;
		pix_t  num;
		pix_t  span;
	} work_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} back_state_t;

endpackage

// File: hdl/mmcs_stream_if.sv
// Valid/ready channel interfaces for pixel input and level output.
interface mmcs_in_if;
	logic                                     valid;
	logic                                     ready;
	logic                                     cmd;
	logic                                     frame_start;
	logic [mmcs_pkg::INPUT_BITS-1:0]          pixel;

	modport source (output valid, output cmd, output frame_start, output pixel, input ready);
	modport sink (input valid, input cmd, input frame_start, input pixel, output ready);
endinterface

interface mmcs_out_if;
	logic                   valid;
	logic                   ready;
	mmcs_pkg::level_t       level;

	modport source (output valid, output level, input ready);
	modport sink (input valid, input level, output ready);
endinterface

// File: hdl/mmcs_front.sv
// Front end: accepts pixels, tracks extremes, classifies apply pixels.
module mmcs_front (
	input  logic             clk,
	input  logic             arst_n,
	mmcs_in_if.sink          pixels,
	output logic             push_valid,
	input  logic             push_ready,
	output mmcs_pkg::work_t  push_data
);

	mmcs_pkg::pix_t low_q;
	mmcs_pkg::pix_t high_q;
	mmcs_pkg::pix_t pix;
	mmcs_pkg::pix_t low_base;
	mmcs_pkg::pix_t high_base;
	logic           take;

	// Drop pixel bits above the configured depth
	assign pix = pixels.pixel[mmcs_pkg::PIXEL_BITS-1:0];

	assign pixels.ready = push_ready;
	assign take = pixels.valid & pixels.ready;

	// Restart extremes on a frame start
	assign low_base = pixels.frame_start ? mmcs_pkg::FULL_SCALE : low_q;
	assign high_base = pixels.frame_start ? '0 : high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= mmcs_pkg::FULL_SCALE;
			high_q <= '0;
		end else if (take && pixels.cmd == mmcs_pkg::CMD_MEASURE) begin
			low_q <= (pix < low_base) ? pix : low_base;
			high_q <= (pix > high_base) ? pix : high_base;
		end
	end

	// Classify apply pixels against the current extremes
	always_comb begin
		push_data.num = pix - low_q;
		push_data.span = high_q - low_q;
		if (high_q <= low_q || pix < low_q) begin
			push_data.kind = mmcs_pkg::KIND_ZERO;
		end else if (pix >= high_q) begin
			push_data.kind = mmcs_pkg::KIND_FULL;
		end else begin
			push_data.kind = mmcs_pkg::KIND_DIV;
		end
	end

	assign push_valid = pixels.valid & (pixels.cmd == mmcs_pkg::CMD_APPLY);

endmodule

// File: hdl/mmcs_queue.sv
// Small FIFO that decouples the front end from the divider back end.
module mmcs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  mmcs_pkg::work_t  push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output mmcs_pkg::work_t  pop_data
);

	mmcs_pkg::work_t                        slots [mmcs_pkg::QUEUE_DEPTH];
	logic [mmcs_pkg::QUEUE_IDX_BITS-1:0]    wr_ptr_q;
	logic [mmcs_pkg::QUEUE_IDX_BITS-1:0]    rd_ptr_q;
	logic [mmcs_pkg::QUEUE_IDX_BITS:0]      count_q;
	logic                                   do_push;
	logic                                   do_pop;

	assign push_ready = (count_q != (mmcs_pkg::QUEUE_IDX_BITS + 1)'(mmcs_pkg::QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data = slots[rd_ptr_q];
	assign do_push = push_valid & push_ready;
	assign do_pop = pop_valid & pop_ready;

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/mmcs_back.sv
// Back end: bit-serial divider for (num * 255) / span and output register.
module mmcs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  mmcs_pkg::work_t  pop_data,
	mmcs_out_if.source       levels
);

	localparam int PB = mmcs_pkg::PIXEL_BITS;
	localparam int LB = mmcs_pkg::LEVEL_BITS;

	mmcs_pkg::back_state_t          state_q;
	mmcs_pkg::back_state_t          state_d;
	logic [mmcs_pkg::STEP_BITS-1:0] step_q;
	mmcs_pkg::pix_t                 rem_q;
	mmcs_pkg::pix_t                 span_q;
	logic [LB-1:0]                  dlow_q;
	mmcs_pkg::level_t               quot_q;
	mmcs_pkg::level_t               level_q;
	logic                           out_valid_q;
	logic [PB+LB-1:0]               prod;
	logic [PB:0]                    trial;
	logic                           fits;
	logic                           load;
	logic                           last_step;
	logic                           emit;

	// Scale by 255 as (num << 8) - num
	assign prod = {pop_data.num, {LB{1'b0}}} - {{LB{1'b0}}, pop_data.num};

	// One restoring division step
	assign trial = {rem_q, dlow_q[LB-1]};
	assign fits = (trial >= {1'b0, span_q});
	assign last_step = (step_q == mmcs_pkg::STEP_BITS'(LB - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mmcs_pkg::BK_IDLE: begin
				if (pop_valid) begin
					state_d = (pop_data.kind == mmcs_pkg::KIND_DIV) ?
						mmcs_pkg::BK_DIV : mmcs_pkg::BK_DONE;
				end
			end
			mmcs_pkg::BK_DIV: begin
				if (last_step) begin
					state_d = mmcs_pkg::BK_DONE;
				end
			end
			mmcs_pkg::BK_DONE: begin
				if (!out_valid_q || levels.ready) begin
					state_d = mmcs_pkg::BK_IDLE;
				end
			end
			default: state_d = mmcs_pkg::BK_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		pop_ready = 1'b0;
		emit = 1'b0;
		unique case (state_q)
			mmcs_pkg::BK_IDLE: pop_ready = 1'b1;
			mmcs_pkg::BK_DIV: ;
			mmcs_pkg::BK_DONE: emit = !out_valid_q || levels.ready;
			default: ;
		endcase
	end

	assign load = pop_valid & pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmcs_pkg::BK_IDLE;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				step_q <= '0;
			end else if (state_q == mmcs_pkg::BK_DIV) begin
				step_q <= step_q + 1'b1;
			end
			// Hold the result until the sink takes the transaction
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (levels.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Divider datapath and result payload
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= prod[PB+LB-1:LB];
			dlow_q <= prod[LB-1:0];
			span_q <= pop_data.span;
			unique case (pop_data.kind)
				mmcs_pkg::KIND_FULL: quot_q <= mmcs_pkg::LEVEL_MAX;
				default: quot_q <= mmcs_pkg::LEVEL_ZERO;
			endcase
		end else if (state_q == mmcs_pkg::BK_DIV) begin
			rem_q <= fits ? PB'(trial - {1'b0, span_q}) : trial[PB-1:0];
			dlow_q <= {dlow_q[LB-2:0], 1'b0};
			quot_q <= {quot_q[LB-2:0], fits};
		end
		if (emit) begin
			level_q <= quot_q;
		end
	end

	assign levels.valid = out_valid_q;
	assign levels.level = level_q;

endmodule

// File: hdl/min_max_contrast_stretch.sv
// Top level: min-max contrast stretch of a pixel stream to 8-bit levels.
// Measure pixels are taken one per cycle while the queue has room and update the extremes at once.
// Apply pixels queue up (4 entries); the back end loads an entry in its idle state, runs the
// bit-serial divider (skipped for pixels that resolve to 0 or 255), then registers the level,
// waiting while the output is stalled. It takes the next entry only once that level is registered.
// Reset clears the extremes to full scale and zero and empties queue and output register.
module min_max_contrast_stretch (
	input  logic        clk,
	input  logic        arst_n,
	mmcs_in_if.sink     pixels,
	mmcs_out_if.source  levels
);

	logic             push_valid;
	logic             push_ready;
	mmcs_pkg::work_t  push_data;
	logic             pop_valid;
	logic             pop_ready;
	mmcs_pkg::work_t  pop_data;

	mmcs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixels     (pixels),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	mmcs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	mmcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.levels    (levels)
	);

endmodule
